// ===== rtl/core/spq_pkg.sv =====
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_PEEK   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Operation broadcast to every cell of the chain in the same cycle
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SHIFT  = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [DATA_W-1:0]   new_job;
        logic [DATA_W-1:0]   new_prio;
    } cell_cmd_t;

endpackage

// ===== rtl/core/sorted_priority_queue_unit.sv =====
// Sorted priority queue of CAPACITY entries held in a chain of cells, highest
// priority in the head cell. Each input transaction carries a mode: insert
// places the task behind every entry of greater or equal priority (equal
// priorities leave in arrival order), remove takes the head task out, peek
// reads it. Every input transaction yields exactly one output transaction with
// the head or removed task, the empty flag, the entry count after the step and
// a status (empty on remove or peek of an empty queue, full on insert into a
// full queue, which is dropped). Fields tied to an empty queue read as zero.
// Throughput is one transaction per clock: every cell compares its priority
// against the incoming one in parallel and loads from itself, its left or
// right neighbor or the new item in the same cycle. Each result is registered
// in the output register; a new transaction is taken while the previous result
// is being handed off, and input stalls only while an output sits stalled.
module sorted_priority_queue_unit
    import spq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                mode,
    input  logic signed [DATA_W-1:0]  task_value,
    input  logic signed [DATA_W-1:0]  priority_req,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [DATA_W-1:0]  front_task,
    output logic                      is_empty_flag,
    output logic [COUNT_W-1:0]        entry_count,
    output logic [1:0]                status
);

    logic              accept;
    logic              queue_empty;
    logic              is_full;
    logic              head_keep;
    logic [DATA_W-1:0] head_job;
    cell_op_t          op;
    cell_cmd_t         cmd;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] result_reg;
    logic [DATA_W-1:0] result_next;
    status_t           status_reg;
    status_t           status_next;

    // Hold input only while a finished result waits downstream
    assign in_stall    = out_valid_reg && out_stall;
    assign accept      = in_valid && !in_stall;
    assign queue_empty = (count_reg == '0);
    assign is_full     = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        op          = OP_HOLD;
        count_next  = count_reg;
        status_next = STATUS_OK;
        result_next = queue_empty ? '0 : head_job;
        case (mode_t'(mode))
            MODE_INSERT:
            begin
                if (is_full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    op          = OP_INSERT;
                    count_next  = count_reg + 1'b1;
                    // New item lands at the head unless the head ranks at or above it
                    result_next = head_keep ? head_job : task_value;
                end
            end
            MODE_REMOVE:
            begin
                if (queue_empty)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    op         = OP_SHIFT;
                    count_next = count_reg - 1'b1;
                end
            end
            MODE_PEEK:
            begin
                if (queue_empty)
                begin
                    status_next = STATUS_EMPTY;
                end
            end
            default:
            begin
                op = OP_HOLD;
            end
        endcase
    end

    // Cells only move on an accepted transaction
    assign cmd.op       = accept ? op : OP_HOLD;
    assign cmd.new_job  = task_value;
    assign cmd.new_prio = priority_req;

    assign out_valid_next = accept ? 1'b1 : (out_valid_reg && out_stall);

    spq_chain u_chain (
        .clk       (clk),
        .cmd       (cmd),
        .count     (count_reg),
        .head_keep (head_keep),
        .head_job  (head_job)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
            status_reg <= status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign front_task    = result_reg;
    assign entry_count   = COUNT_W'(count_reg);
    assign is_empty_flag = (count_reg == '0);
    assign status        = status_reg;

endmodule

// ===== rtl/core/spq_cell.sv =====
module spq_cell
    import spq_pkg::*;
(
    input  logic              clk,
    input  cell_cmd_t         cmd,
    input  logic              occupied,
    input  logic              keep_prev,
    input  logic [DATA_W-1:0] prev_job,
    input  logic [DATA_W-1:0] prev_prio,
    input  logic [DATA_W-1:0] next_job,
    input  logic [DATA_W-1:0] next_prio,
    output logic              keep,
    output logic [DATA_W-1:0] job,
    output logic [DATA_W-1:0] prio
);

    logic [DATA_W-1:0] job_reg;
    logic [DATA_W-1:0] job_next;
    logic [DATA_W-1:0] prio_reg;
    logic [DATA_W-1:0] prio_next;

    // Stay in place when this entry ranks at or above the new one
    assign keep = occupied && ($signed(prio_reg) >= $signed(cmd.new_prio));
    assign job  = job_reg;
    assign prio = prio_reg;

    always_comb
    begin
        job_next  = job_reg;
        prio_next = prio_reg;
        case (cmd.op)
            OP_INSERT:
            begin
                if (!keep)
                begin
                    if (keep_prev)
                    begin
                        job_next  = cmd.new_job;
                        prio_next = cmd.new_prio;
                    end
                    else
                    begin
                        job_next  = prev_job;
                        prio_next = prev_prio;
                    end
                end
            end
            OP_SHIFT:
            begin
                job_next  = next_job;
                prio_next = next_prio;
            end
            default:
            begin
                job_next  = job_reg;
                prio_next = prio_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        prio_reg <= prio_next;
    end

endmodule

// ===== rtl/core/spq_chain.sv =====
module spq_chain
    import spq_pkg::*;
(
    input  logic              clk,
    input  cell_cmd_t         cmd,
    input  logic [CNT_W-1:0]  count,
    output logic              head_keep,
    output logic [DATA_W-1:0] head_job
);

    logic [DATA_W-1:0] job_w  [CAPACITY];
    logic [DATA_W-1:0] prio_w [CAPACITY];
    logic              keep_w [CAPACITY];

    assign head_keep = keep_w[0];
    assign head_job  = job_w[0];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic              occ;
        logic              kp;
        logic [DATA_W-1:0] pj;
        logic [DATA_W-1:0] pp;
        logic [DATA_W-1:0] nj;
        logic [DATA_W-1:0] np;

        assign occ = CNT_W'(i) < count;

        if (i == 0)
        begin : g_first
            assign kp = 1'b1;
            assign pj = cmd.new_job;
            assign pp = cmd.new_prio;
        end
        else
        begin : g_mid
            assign kp = keep_w[i-1];
            assign pj = job_w[i-1];
            assign pp = prio_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            // Vacated on a shift; contents no longer count
            assign nj = job_w[i];
            assign np = prio_w[i];
        end
        else
        begin : g_inner
            assign nj = job_w[i+1];
            assign np = prio_w[i+1];
        end

        spq_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .occupied  (occ),
            .keep_prev (kp),
            .prev_job  (pj),
            .prev_prio (pp),
            .next_job  (nj),
            .next_prio (np),
            .keep      (keep_w[i]),
            .job       (job_w[i]),
            .prio      (prio_w[i])
        );
    end

endmodule

// ===== rtl/core/spq_checker.sv =====
module spq_checker
    import spq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic [1:0]                mode,
    input  logic signed [DATA_W-1:0]  task_value,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic signed [DATA_W-1:0]  front_task,
    input  logic                      is_empty_flag,
    input  logic [COUNT_W-1:0]        entry_count,
    input  logic [1:0]                status
);

    // Empty flag agrees with the reported count
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty_flag == (entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    // A failed remove or peek shows an empty queue and a zero task
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_EMPTY) |-> (is_empty_flag && front_task == '0))
        else $error("empty status with data");

    // A dropped insert only happens at full capacity
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_FULL) |-> (entry_count == COUNT_W'(CAPACITY)))
        else $error("full status below capacity");

    // An accepted insert into an empty queue returns its own task
    a_insert_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && mode == MODE_INSERT && out_valid && !out_stall
         && is_empty_flag)
        |=> (out_valid && front_task == $past(task_value) && entry_count == 5'd1))
        else $error("insert into empty queue lost its task");

    // Stalled output holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(front_task)
         && $stable(entry_count) && $stable(status)))
        else $error("stalled output changed");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (.*);

// ===== tb/queue_order_checker.sv =====
module queue_order_checker
    import spq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic [1:0]                mode,
    input  logic signed [DATA_W-1:0]  task_value,
    input  logic signed [DATA_W-1:0]  priority_req,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic signed [DATA_W-1:0]  front_task,
    input  logic                      is_empty_flag,
    input  logic [COUNT_W-1:0]        entry_count,
    input  logic [1:0]                status,
    output int unsigned               mismatches,
    output int unsigned               pending,
    output int unsigned               full_hits,
    output int unsigned               empty_hits,
    output int unsigned               results
);

    typedef struct packed {
        logic signed [DATA_W-1:0] job;
        logic signed [DATA_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] front;
        logic                     empty;
        logic [COUNT_W-1:0]       count;
        logic [1:0]               stat;
    } outcome_t;

    // Model of the queue contents, head at index 0
    entry_t      sorted_entries[$];
    outcome_t    due_outcomes[$];
    outcome_t    want;
    int unsigned n_bad;
    int unsigned n_full;
    int unsigned n_empty;
    int unsigned n_done;

    // Apply one command to the model and return the result it should produce
    function automatic outcome_t apply_command(input logic [1:0] op,
                                               input logic signed [DATA_W-1:0] job,
                                               input logic signed [DATA_W-1:0] prio);
        outcome_t r;
        entry_t   slot;
        int       pos;
        r       = '0;
        r.stat  = STATUS_OK;
        case (op)
            MODE_INSERT:
            begin
                if (sorted_entries.size() >= CAPACITY)
                begin
                    r.stat = STATUS_FULL;
                end
                else
                begin
                    // Walk past every entry of greater or equal priority
                    pos = 0;
                    while (pos < sorted_entries.size() &&
                           $signed(sorted_entries[pos].prio) >= $signed(prio))
                        pos++;
                    slot.job  = job;
                    slot.prio = prio;
                    sorted_entries.insert(pos, slot);
                end
                if (sorted_entries.size() != 0)
                    r.front = sorted_entries[0].job;
            end
            MODE_REMOVE:
            begin
                if (sorted_entries.size() == 0)
                begin
                    r.stat = STATUS_EMPTY;
                end
                else
                begin
                    r.front = sorted_entries[0].job;
                    void'(sorted_entries.pop_front());
                end
            end
            MODE_PEEK:
            begin
                if (sorted_entries.size() == 0)
                    r.stat = STATUS_EMPTY;
                else
                    r.front = sorted_entries[0].job;
            end
            default:
            begin
                if (sorted_entries.size() != 0)
                    r.front = sorted_entries[0].job;
            end
        endcase
        r.empty = (sorted_entries.size() == 0);
        r.count = COUNT_W'(sorted_entries.size());
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sorted_entries.delete();
            due_outcomes.delete();
        end
        else
        begin
            // Compare the result transaction before taking in a new command
            if (out_valid && !out_stall)
            begin
                n_done++;
                if (due_outcomes.size() == 0)
                begin
                    n_bad++;
                    $error("unexpected result transaction: front_task %0d status %0d",
                           front_task, status);
                end
                else
                begin
                    want = due_outcomes.pop_front();
                    if (front_task !== want.front)
                    begin
                        n_bad++;
                        $error("front_task: expected %0d, actual %0d",
                               $signed(want.front), front_task);
                    end
                    if (is_empty_flag !== want.empty)
                    begin
                        n_bad++;
                        $error("is_empty_flag: expected %0d, actual %0d",
                               want.empty, is_empty_flag);
                    end
                    if (entry_count !== want.count)
                    begin
                        n_bad++;
                        $error("entry_count: expected %0d, actual %0d",
                               want.count, entry_count);
                    end
                    if (status !== want.stat)
                    begin
                        n_bad++;
                        $error("status: expected %0d, actual %0d", want.stat, status);
                    end
                    if (want.stat == STATUS_FULL)
                        n_full++;
                    if (want.stat == STATUS_EMPTY)
                        n_empty++;
                end
            end
            if (in_valid && !in_stall)
                due_outcomes.insert(due_outcomes.size(),
                                    apply_command(mode, task_value, priority_req));
        end
        mismatches <= n_bad;
        pending    <= due_outcomes.size();
        full_hits  <= n_full;
        empty_hits <= n_empty;
        results    <= n_done;
    end

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import spq_pkg::*;

    // The fourth mode code is undefined; the block must treat it as a no-op
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;
    localparam int unsigned TOTAL_ITEMS  = 1050;
    localparam int unsigned CALM_ITEMS   = 120;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [1:0]                mode;
    logic signed [DATA_W-1:0]  task_value;
    logic signed [DATA_W-1:0]  priority_req;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [DATA_W-1:0]  front_task;
    logic                      is_empty_flag;
    logic [COUNT_W-1:0]        entry_count;
    logic [1:0]                status;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned full_hits;
    int unsigned empty_hits;
    int unsigned results;

    int unsigned stall_rate;     // chance of a receiver stall burst, in tenths
    int unsigned rx_left;        // cycles left in the current stall burst
    int unsigned cycles;
    int unsigned sent;
    int unsigned mode_tally[4];
    int unsigned phase;
    int unsigned gap_rate;

    sorted_priority_queue_unit dut (.*);

    queue_order_checker order_check (.*);

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results pending", cycles, pending);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Receiver: stall in random bursts at the current rate
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_left = 0;
        end
        else if (rx_left != 0)
        begin
            out_stall <= 1'b1;
            rx_left = rx_left - 1;
        end
        else if (stall_rate != 0 && $urandom_range(0, 9) < stall_rate)
        begin
            out_stall <= 1'b1;
            rx_left = $urandom_range(0, 6);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Drive one command and hold it until the transaction completes
    task automatic send_item(input logic [1:0] op,
                             input logic [DATA_W-1:0] job,
                             input logic [DATA_W-1:0] prio);
        in_valid     <= 1'b1;
        mode         <= op;
        task_value   <= job;
        priority_req <= prio;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        mode_tally[op]++;
        sent++;
    endtask

    // Drop valid for the requested pause
    task automatic pause_sender(input int unsigned n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Favor a few small values and the extremes so that ties and ordering at
    // the ends of the signed range show up often
    function automatic logic [DATA_W-1:0] pick_priority();
        int p;
        case ($urandom_range(0, 7))
            0:       p = 32'h7FFF_FFFF;
            1:       p = 32'h8000_0000;
            2, 3, 4: p = int'($urandom_range(0, 6)) - 3;
            default: p = $urandom();
        endcase
        return p;
    endfunction

    // Issue n random commands with the given mix (percent per mode; the rest
    // go to the undefined mode) and sender gaps at gap_pct tenths
    task automatic run_phase(input int unsigned n, input int unsigned w_ins,
                             input int unsigned w_rem, input int unsigned w_peek,
                             input int unsigned gap_pct);
        int unsigned r;
        logic [1:0]  op;
        repeat (n)
        begin
            if (gap_pct != 0 && $urandom_range(0, 9) < gap_pct)
                pause_sender($urandom_range(1, 7));
            r = $urandom_range(0, 99);
            if (r < w_ins)
                op = MODE_INSERT;
            else if (r < w_ins + w_rem)
                op = MODE_REMOVE;
            else if (r < w_ins + w_rem + w_peek)
                op = MODE_PEEK;
            else
                op = MODE_UNUSED;
            send_item(op, $urandom(), pick_priority());
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = MODE_INSERT;
        task_value   = '0;
        priority_req = '0;
        stall_rate   = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Hit the empty queue with every command first
        send_item(MODE_REMOVE, 32'h1234_5678, 32'h0000_0000);
        send_item(MODE_PEEK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(MODE_UNUSED, 32'h0000_0000, 32'h0000_0000);

        // Extreme tasks and priorities, then an equal-priority insert that must
        // land behind the earlier one
        send_item(MODE_INSERT, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(MODE_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(MODE_INSERT, 32'hFFFF_FFFF, 32'h8000_0000);
        send_item(MODE_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_item(MODE_PEEK, 32'h5555_5555, 32'hAAAA_AAAA);
        send_item(MODE_UNUSED, 32'hAAAA_AAAA, 32'h5555_5555);
        send_item(MODE_REMOVE, 32'h0000_0000, 32'h0000_0000);
        send_item(MODE_REMOVE, 32'h0000_0000, 32'h0000_0000);

        // Fill to capacity with many ties, then overflow once
        for (int i = 0; i < CAPACITY - 2; i++)
            send_item(MODE_INSERT, 32'(i + 100), 32'(i % 3));
        send_item(MODE_INSERT, 32'hDEAD_BEEF, 32'h7FFF_FFFF);

        // Random phases rotate through drain, fill and mixed traffic, each with
        // its own idling rates so gaps land in every state of the queue
        phase = 0;
        while (sent < TOTAL_ITEMS - CALM_ITEMS)
        begin
            gap_rate    = $urandom_range(0, 2) * 3;
            stall_rate <= $urandom_range(0, 2) * 3;
            if (phase == 3)
            begin
                // Let the pipeline run dry before resuming
                pause_sender(1);
                while (pending != 0)
                    @(posedge clk);
            end
            case (phase % 3)
                0:       run_phase($urandom_range(30, 80), 20, 60, 12, gap_rate);
                1:       run_phase($urandom_range(30, 80), 75, 15, 7, gap_rate);
                default: run_phase($urandom_range(30, 80), 40, 35, 18, gap_rate);
            endcase
            phase++;
        end

        // Final stretch at full rate on both sides; let any stall burst finish
        stall_rate <= 0;
        @(posedge clk);
        while (out_stall)
            @(posedge clk);
        run_phase(CALM_ITEMS, 40, 35, 18, 0);

        // Drain outstanding results, then watch for stray ones
        pause_sender(1);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("issued %0d commands: %0d insert, %0d remove, %0d peek, %0d undefined mode",
                 sent, mode_tally[MODE_INSERT], mode_tally[MODE_REMOVE],
                 mode_tally[MODE_PEEK], mode_tally[MODE_UNUSED]);
        $display("checked %0d results; %0d inserts hit a full queue, %0d reads an empty one",
                 results, full_hits, empty_hits);
        if (mismatches == 0 && pending == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/spq_chain.sv
rtl/core/sorted_priority_queue_unit.sv
rtl/core/spq_checker.sv
tb/queue_order_checker.sv
tb/testbench.sv
